### rtl/spi_rxf_pkg.sv
`timescale 1ns / 1ps
// Shared types, register offsets and bit positions of the serial controller block.
package spi_rxf_pkg;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_LOAD  = 2'd2
   } action_type;

   typedef logic [1:0] csr_idx_type;

   localparam csr_idx_type CSR_FLASH_ATTACHED = 2'd0;
   localparam csr_idx_type CSR_IMAGE_ENABLE   = 2'd1;
   localparam csr_idx_type CSR_WINDOW_BASE    = 2'd2;

   localparam int CSR_DATA_W = 24;
   localparam int ADDR_W     = 24;

   localparam logic [13:0] OFF_MCR   = 14'h0000;
   localparam logic [13:0] OFF_TCR   = 14'h0008;
   localparam logic [13:0] OFF_CTAR0 = 14'h000C;
   localparam logic [13:0] OFF_CTAR7 = 14'h0028;
   localparam logic [13:0] OFF_SR    = 14'h002C;
   localparam logic [13:0] OFF_RSER  = 14'h0030;
   localparam logic [13:0] OFF_PUSHR = 14'h0034;
   localparam logic [13:0] OFF_POPR  = 14'h0038;

   // Status and push word bit positions.
   localparam int SR_TCF    = 31;
   localparam int SR_EOQF   = 28;
   localparam int SR_RFDF   = 17;
   localparam int PU_CONT   = 31;
   localparam int PU_EOQ    = 27;
   localparam int PU_CTCNT  = 26;

   localparam logic [7:0]        NOR_READ_CMD = 8'h03;
   localparam logic [7:0]        RX_SAT       = 8'd15;
   localparam logic [ADDR_W-1:0] BASE_RESET   = 24'h340000;

   // Control from the bus decode to the receive queue.
   typedef struct packed {
      logic push;
      logic pop;
      logic from_image;
   } queue_ctl_type;

endpackage

### rtl/spi_rxf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
interface spi_rxf_req_if;
   import spi_rxf_pkg::*;

   logic        valid;
   logic        ready;
   action_type  action;
   logic [13:0] offset;
   logic [31:0] write_data;
   logic [16:0] image_index;
   logic [7:0]  image_byte;

   modport source (output valid, action, offset, write_data, image_index, image_byte,
                   input ready);
   modport sink   (input valid, action, offset, write_data, image_index, image_byte,
                   output ready);
endinterface

interface spi_rxf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

### rtl/spi_rxf_image_mem.sv
`timescale 1ns / 1ps
// Image byte memory with a zeroing sweep after reset and a registered read port.
module spi_rxf_image_mem #(
   parameter int DEPTH = 131072,
   parameter int AW    = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   output logic          busy
);
   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;
endmodule

### rtl/spi_rxf_rx_queue.sv
`timescale 1ns / 1ps
// Receive queue that overwrites its oldest entry when full, with a deferred byte write held in a pending register.
module spi_rxf_rx_queue #(
   parameter int DEPTH  = 16,
   parameter int HEAD_W = 4,
   parameter int FILL_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  spi_rxf_pkg::queue_ctl_type ctl,
   input  logic [7:0]                 image_q,
   output logic [FILL_W-1:0]          fill,
   output logic [7:0]                 pop_byte
);
   import spi_rxf_pkg::*;

   logic [7:0]        entry_ff [DEPTH];
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              pend_ff, pend_in;
   logic [HEAD_W-1:0] pend_idx_ff, pend_idx_in;
   logic              pend_img_ff, pend_img_in;
   logic [7:0]        pend_byte;
   logic [HEAD_W-1:0] head_inc;
   logic [HEAD_W:0]   wr_sum;
   logic              full;

   // The answer byte of a push lands in the cycle after it, once the image read returns.
   assign pend_byte = pend_img_ff ? image_q : 8'h00;
   assign full      = (fill_ff == FILL_W'(DEPTH));
   assign head_inc  = (head_ff == HEAD_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign wr_sum    = {1'b0, head_ff} + (HEAD_W + 1)'(fill_ff);

   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      pend_img_in = pend_img_ff;
      if (ctl.push) begin
         pend_in     = 1'b1;
         pend_img_in = ctl.from_image;
         if (full) begin
            // Overwrite: the oldest slot becomes the newest.
            head_in     = head_inc;
            pend_idx_in = head_ff;
         end else begin
            fill_in = fill_ff + 1'b1;
            if (wr_sum >= (HEAD_W + 1)'(DEPTH)) begin
               pend_idx_in = HEAD_W'(wr_sum - (HEAD_W + 1)'(DEPTH));
            end else begin
               pend_idx_in = wr_sum[HEAD_W-1:0];
            end
         end
      end else if (ctl.pop && fill_ff != '0) begin
         head_in = head_inc;
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      pend_img_ff <= pend_img_in;
      if (pend_ff) begin
         entry_ff[pend_idx_ff] <= pend_byte;
      end
   end

   assign fill     = fill_ff;
   assign pop_byte = (pend_ff && pend_idx_ff == head_ff) ? pend_byte : entry_ff[head_ff];
endmodule

### rtl/spi_rxf_if_dummy_guard.sv
`timescale 1ns / 1ps
// Request register stage that holds one accepted beat until the response slot frees up.
module spi_rxf_req_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    busy,
   input  logic                    advance,
   spi_rxf_req_if.sink             req,
   output logic                    s1_valid,
   output spi_rxf_pkg::action_type s1_action,
   output logic [13:0]             s1_offset,
   output logic [31:0]             s1_write_data,
   output logic [16:0]             s1_image_index,
   output logic [7:0]              s1_image_byte
);
   import spi_rxf_pkg::*;

   logic        valid_ff;
   action_type  action_ff;
   logic [13:0] offset_ff;
   logic [31:0] write_data_ff;
   logic [16:0] image_index_ff;
   logic [7:0]  image_byte_ff;
   logic        take;

   assign req.ready = !busy && (!valid_ff || advance);
   assign take      = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         action_ff      <= req.action;
         offset_ff      <= req.offset;
         write_data_ff  <= req.write_data;
         image_index_ff <= req.image_index;
         image_byte_ff  <= req.image_byte;
      end
   end

   assign s1_valid       = valid_ff;
   assign s1_action      = action_ff;
   assign s1_offset      = offset_ff;
   assign s1_write_data  = write_data_ff;
   assign s1_image_index = image_index_ff;
   assign s1_image_byte  = image_byte_ff;
endmodule

### rtl/spi_controller_rx_fifo_nor_read.sv
`timescale 1ns / 1ps
// Top level of the serial controller with receive queue and serial NOR read parser.
// Usage: each request beat is one bus read, one bus write or one image byte load, and
// yields exactly one response beat carrying the read value (zero for writes and loads).
// A beat is captured into a request register and executed once the response register is
// free: the register file, frame parser and receive queue are updated and the response
// register is loaded, so the block sustains one beat per clock while each response is
// taken at once. A waiting response still lets one beat into an empty request register.
// After reset the block zeroes the image memory one byte per cycle over all IMAGE_BYTES
// bytes (131072 by default); req.ready stays low during that sweep, while configuration
// writes are taken at any time. The user must write the configuration (NOR parser present,
// image enable, window base) through csr_we/csr_index/csr_wdata only while the block is
// idle; the block does not enforce this. Push bytes inside the image window read the image
// memory; the byte is queued via a pending register and forwarded to a pop right behind it.
module spi_controller_rx_fifo_nor_read #(
   parameter int RX_DEPTH    = 16,
   parameter int IMAGE_BYTES = 131072
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  spi_rxf_pkg::csr_idx_type               csr_index,
   input  logic [spi_rxf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   spi_rxf_req_if.sink                            req,
   spi_rxf_rsp_if.source                          rsp
);
   import spi_rxf_pkg::*;

   localparam int IMG_AW = $clog2(IMAGE_BYTES);
   localparam int HEAD_W = $clog2(RX_DEPTH);
   localparam int FILL_W = $clog2(RX_DEPTH + 1);

   // Configuration registers.
   logic              flash_attached_ff;
   logic              image_enable_ff;
   logic [ADDR_W-1:0] window_base_ff;

   // Bus-visible registers. Only the two sticky status bits are set by hardware; the rest hold bus writes.
   logic [31:0] module_ctrl_ff;
   logic [31:0] xfer_count_ff;
   logic [31:0] timing_ff [8];
   logic [31:0] irq_enable_ff;
   logic        eoqf_ff, eoqf_in;
   logic        tcf_ff, tcf_in;

   // Frame parser state.
   logic              in_frame_ff, in_frame_in;
   logic [7:0]        frame_cmd_ff, frame_cmd_in;
   logic [ADDR_W-1:0] flash_ptr_ff, flash_ptr_in;
   logic [1:0]        addr_seen_ff, addr_seen_in;

   // Response register.
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // Executing beat.
   logic        s1_valid;
   action_type  s1_action;
   logic [13:0] s1_offset;
   logic [31:0] s1_write_data;
   logic [16:0] s1_image_index;
   logic [7:0]  s1_image_byte;

   logic              busy;
   logic              advance;
   logic              do_read, do_write, do_load;
   logic              timing_sel;
   logic [13:0]       timing_rel;
   logic [2:0]        timing_idx;
   logic              push_we;
   logic              data_phase;
   logic [ADDR_W-1:0] win_diff;
   logic              win_hit;
   logic [20:0]       load_idx;
   logic              load_we;
   logic              img_rd_en;
   logic [7:0]        image_q;
   logic [FILL_W-1:0] rx_fill;
   logic [7:0]        pop_byte;
   logic [7:0]        fill_ext;
   logic [3:0]        rx_level;
   logic [31:0]       status_view;
   logic [31:0]       read_val;
   queue_ctl_type     q_ctl;

   spi_rxf_req_stage u_req_stage (
      .clock          (clock),
      .reset          (reset),
      .busy           (busy),
      .advance        (advance),
      .req            (req),
      .s1_valid       (s1_valid),
      .s1_action      (s1_action),
      .s1_offset      (s1_offset),
      .s1_write_data  (s1_write_data),
      .s1_image_index (s1_image_index),
      .s1_image_byte  (s1_image_byte)
   );

   // The executing beat retires when the response register is empty or being drained.
   assign advance  = s1_valid && (!rsp_valid_ff || rsp.ready);
   assign do_read  = advance && (s1_action == ACT_READ);
   assign do_write = advance && (s1_action == ACT_WRITE);
   assign do_load  = advance && (s1_action == ACT_LOAD);

   // Timing registers sit on word-aligned offsets between the first and the last one.
   assign timing_sel = (s1_offset >= OFF_CTAR0) && (s1_offset <= OFF_CTAR7)
                       && (s1_offset[1:0] == 2'b00);
   assign timing_rel = s1_offset - OFF_CTAR0;
   assign timing_idx = timing_rel[4:2];

   assign push_we = do_write && !timing_sel && (s1_offset == OFF_PUSHR);

   // A push inside an open read frame with all three address bytes seen returns data
   // from the current flash pointer. No frame close from the push word can precede it,
   // because a close would leave the frame shut and the byte would open a new one.
   assign data_phase = in_frame_ff && !s1_write_data[PU_CTCNT] && flash_attached_ff
                       && (frame_cmd_ff == NOR_READ_CMD) && (addr_seen_ff == 2'd3);
   assign win_diff   = flash_ptr_ff - window_base_ff;
   assign win_hit    = image_enable_ff && (flash_ptr_ff >= window_base_ff)
                       && (win_diff < ADDR_W'(IMAGE_BYTES));
   assign img_rd_en  = push_we && data_phase && win_hit;

   assign load_idx = {4'b0000, s1_image_index};
   assign load_we  = do_load && (load_idx < 21'(IMAGE_BYTES));

   spi_rxf_image_mem #(
      .DEPTH (IMAGE_BYTES),
      .AW    (IMG_AW)
   ) u_image_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_we),
      .wr_addr (load_idx[IMG_AW-1:0]),
      .wr_data (s1_image_byte),
      .rd_en   (img_rd_en),
      .rd_addr (win_diff[IMG_AW-1:0]),
      .rd_data (image_q),
      .busy    (busy)
   );

   assign q_ctl.push       = push_we;
   assign q_ctl.pop        = do_read && !timing_sel && (s1_offset == OFF_POPR);
   assign q_ctl.from_image = img_rd_en;

   spi_rxf_rx_queue #(
      .DEPTH  (RX_DEPTH),
      .HEAD_W (HEAD_W),
      .FILL_W (FILL_W)
   ) u_rx_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .image_q  (image_q),
      .fill     (rx_fill),
      .pop_byte (pop_byte)
   );

   // Status view: sticky bits, saturated receive count and receive-not-empty.
   assign fill_ext = 8'(rx_fill);
   assign rx_level = (fill_ext < RX_SAT) ? fill_ext[3:0] : RX_SAT[3:0];

   always_comb begin
      status_view          = '0;
      status_view[SR_TCF]  = tcf_ff;
      status_view[SR_EOQF] = eoqf_ff;
      status_view[SR_RFDF] = (rx_fill != '0);
      status_view[7:4]     = rx_level;
   end

   always_comb begin
      if (timing_sel) begin
         read_val = timing_ff[timing_idx];
      end else begin
         case (s1_offset)
            OFF_MCR:  read_val = module_ctrl_ff;
            OFF_TCR:  read_val = xfer_count_ff;
            OFF_SR:   read_val = status_view;
            OFF_RSER: read_val = irq_enable_ff;
            OFF_POPR: read_val = (rx_fill != '0) ? {24'h000000, pop_byte} : 32'h0;
            default:  read_val = 32'h0;
         endcase
      end
   end

   assign rsp_data_in = do_read ? read_val : 32'h0;

   // Frame parser: optional close, the byte exchange, then the end-of-frame check.
   always_comb begin
      in_frame_in  = in_frame_ff;
      frame_cmd_in = frame_cmd_ff;
      flash_ptr_in = flash_ptr_ff;
      addr_seen_in = addr_seen_ff;
      if (push_we) begin
         if (s1_write_data[PU_CTCNT]) begin
            in_frame_in  = 1'b0;
            frame_cmd_in = 8'h00;
            flash_ptr_in = '0;
            addr_seen_in = 2'd0;
         end
         if (!in_frame_in) begin
            in_frame_in  = 1'b1;
            frame_cmd_in = s1_write_data[7:0];
            flash_ptr_in = '0;
            addr_seen_in = 2'd0;
         end else if (flash_attached_ff && frame_cmd_in == NOR_READ_CMD) begin
            if (addr_seen_in != 2'd3) begin
               flash_ptr_in = {flash_ptr_in[15:0], s1_write_data[7:0]};
               addr_seen_in = addr_seen_in + 1'b1;
            end else begin
               flash_ptr_in = flash_ptr_in + 1'b1;
            end
         end
         if (!s1_write_data[PU_CONT] || s1_write_data[PU_EOQ]) begin
            in_frame_in  = 1'b0;
            frame_cmd_in = 8'h00;
            flash_ptr_in = '0;
            addr_seen_in = 2'd0;
         end
      end
   end

   // Sticky status: writing ones clears, every push sets both bits.
   always_comb begin
      eoqf_in = eoqf_ff;
      tcf_in  = tcf_ff;
      if (do_write && !timing_sel && s1_offset == OFF_SR) begin
         eoqf_in = eoqf_ff & ~s1_write_data[SR_EOQF];
         tcf_in  = tcf_ff & ~s1_write_data[SR_TCF];
      end
      if (push_we) begin
         eoqf_in = 1'b1;
         tcf_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_attached_ff <= 1'b1;
         image_enable_ff   <= 1'b0;
         window_base_ff    <= BASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLASH_ATTACHED: flash_attached_ff <= csr_wdata[0];
            CSR_IMAGE_ENABLE:   image_enable_ff   <= csr_wdata[0];
            CSR_WINDOW_BASE:    window_base_ff    <= csr_wdata[ADDR_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_ctrl_ff <= '0;
         xfer_count_ff  <= '0;
         irq_enable_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            timing_ff[i] <= '0;
         end
      end else if (do_write) begin
         if (timing_sel) begin
            timing_ff[timing_idx] <= s1_write_data;
         end else begin
            case (s1_offset)
               OFF_MCR:  module_ctrl_ff <= s1_write_data;
               OFF_TCR:  xfer_count_ff  <= s1_write_data;
               OFF_RSER: irq_enable_ff  <= s1_write_data;
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eoqf_ff      <= 1'b0;
         tcf_ff       <= 1'b0;
         in_frame_ff  <= 1'b0;
         frame_cmd_ff <= 8'h00;
         flash_ptr_ff <= '0;
         addr_seen_ff <= 2'd0;
      end else begin
         eoqf_ff      <= eoqf_in;
         tcf_ff       <= tcf_in;
         in_frame_ff  <= in_frame_in;
         frame_cmd_ff <= frame_cmd_in;
         flash_ptr_ff <= flash_ptr_in;
         addr_seen_ff <= addr_seen_in;
      end
   end

   // Response register: loaded when a beat retires, emptied when the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
endmodule
